### rtl/integer_to_ascii_radix_defines.svh
// Assertion macros shared by the integer to ASCII converter modules.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ITOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/itoa_pkg.sv
// Shared types, codes and helper functions for the integer to ASCII converter.
`default_nettype none

package itoa_pkg;

    // Operand size codes.
    localparam logic [1:0] SIZE_16 = 2'd0;
    localparam logic [1:0] SIZE_32 = 2'd1;

    // Radix codes; both unused codes are treated as hexadecimal.
    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;

    // Bits of the quotient handled by one decimal division step.
    localparam int CHUNK_BITS = 8;

    localparam logic [7:0] MINUS_CHAR = 8'h2d;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] ALPHA_BASE = 8'h57;
    localparam logic [4:0] TEN        = 5'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic sign_out;
        logic rd_en;
        logic digit_out;
    } itoa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;
        logic negative;
        logic cnt_one;
    } itoa_sts_t;

    // Result of dividing one chunk, with a carried remainder, by ten.
    typedef struct packed {
        logic [CHUNK_BITS-1:0] quot;
        logic [3:0]            rem;
    } div_res_t;

    // Long division of a chunk by ten, one quotient bit per step, MSB first.
    function automatic div_res_t div10_chunk(input logic [3:0] rem_in,
                                             input logic [CHUNK_BITS-1:0] chunk);
        div_res_t   res;
        logic [3:0] r;
        logic [4:0] t;
        r = rem_in;
        res.quot = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            t = {r, chunk[i]};
            if (t >= TEN)
            begin
                res.quot[i] = 1'b1;
                t = t - TEN;
            end
            r = t[3:0];
        end
        res.rem = r;
        return res;
    endfunction

    // ASCII text of one digit value, lower-case for ten and above.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = ZERO_CHAR + 8'(d);
        else
            c = ALPHA_BASE + 8'(d);
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/itoa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module itoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/itoa_dp.sv
// Datapath: magnitude, digit division, digit store and output character register.
`default_nettype none
`include "integer_to_ascii_radix_defines.svh"

module itoa_dp
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS  = 64,
    parameter int DIGIT_SLOTS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire itoa_cmd_t   cmd,
    output itoa_sts_t        sts,
    input  wire logic [63:0] value,
    input  wire logic [1:0]  size_code,
    input  wire logic        is_signed,
    input  wire logic [1:0]  radix_code,
    output logic      [7:0]  character,
    output logic             last
);

    localparam int CHUNKS    = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int WORD_BITS = CHUNKS * CHUNK_BITS;
    localparam int CHUNK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW        = $clog2(DIGIT_SLOTS);
    localparam int CW        = $clog2(DIGIT_SLOTS + 1);

    logic [WORD_BITS-1:0]  q_reg, q_next;
    logic [3:0]            rem_reg, rem_next;
    logic [CHUNK_W-1:0]    chunk_reg, chunk_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  neg_reg, neg_next;
    logic [1:0]            radix_reg, radix_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic [6:0]            width_eff;
    logic [VALUE_BITS-1:0] mask, top_mask, v_masked, mag;
    logic                  sign_bit, load_neg;
    div_res_t              div;
    logic [WORD_BITS-1:0]  q_step;
    logic [3:0]            digit;
    logic                  digit_done;
    logic                  wr_en;
    logic [3:0]            rd_data;

    // Operand width from the size code, limited to the supported width.
    always_comb
    begin
        case (size_code)
            SIZE_16: width_eff = 7'd16;
            SIZE_32: width_eff = 7'd32;
            default: width_eff = 7'd64;
        endcase
        if (width_eff > 7'(VALUE_BITS))
            width_eff = 7'(VALUE_BITS);
    end

    // Masking, sign detection and two's complement magnitude.
    always_comb
    begin
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            mask[i]     = 7'(i) < width_eff;
            top_mask[i] = 7'(i + 1) == width_eff;
        end
        v_masked = value[VALUE_BITS-1:0] & mask;
        sign_bit = |(v_masked & top_mask);
        load_neg = is_signed && (radix_code != RADIX_OCT) && sign_bit;
        mag      = load_neg ? ((~v_masked + 1'b1) & mask) : v_masked;
    end

    // One division step: a chunk of long division by ten, or a shift for octal and hex.
    always_comb
    begin
        div = div10_chunk(rem_reg, q_reg[WORD_BITS-1 -: CHUNK_BITS]);
        if (radix_reg == RADIX_DEC)
        begin
            q_step     = {q_reg[WORD_BITS-CHUNK_BITS-1:0], div.quot};
            digit      = div.rem;
            digit_done = chunk_reg == CHUNK_W'(CHUNKS - 1);
        end
        else if (radix_reg == RADIX_OCT)
        begin
            q_step     = q_reg >> 3;
            digit      = {1'b0, q_reg[2:0]};
            digit_done = 1'b1;
        end
        else
        begin
            q_step     = q_reg >> 4;
            digit      = q_reg[3:0];
            digit_done = 1'b1;
        end
    end

    assign wr_en = cmd.step && digit_done;

    // Next-state logic of the datapath registers.
    always_comb
    begin
        q_next     = q_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (cmd.load)
        begin
            q_next     = WORD_BITS'(mag);
            rem_next   = '0;
            chunk_next = '0;
            count_next = '0;
            neg_next   = load_neg;
            radix_next = radix_code;
        end
        if (cmd.step)
        begin
            q_next = q_step;
            if (digit_done)
            begin
                rem_next   = '0;
                chunk_next = '0;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                rem_next   = div.rem;
                chunk_next = chunk_reg + 1'b1;
            end
        end
        if (cmd.sign_out)
        begin
            char_next = MINUS_CHAR;
            last_next = 1'b0;
        end
        if (cmd.digit_out)
        begin
            char_next  = digit_char(rd_data);
            last_next  = count_reg == CW'(1);
            count_next = count_reg - 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg     <= '0;
            rem_reg   <= '0;
            chunk_reg <= '0;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            radix_reg <= '0;
        end
        else
        begin
            q_reg     <= q_next;
            rem_reg   <= rem_next;
            chunk_reg <= chunk_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
        end
    end

    // Output character register.
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // Digit store, least significant digit first.
    itoa_ram #(
        .WIDTH (4),
        .DEPTH (DIGIT_SLOTS)
    ) u_digit_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (digit),
        .rd_en   (cmd.rd_en),
        .rd_addr (AW'(count_reg - 1'b1)),
        .rd_data (rd_data)
    );

    // Status towards the controller.
    always_comb
    begin
        sts.conv_last = digit_done &&
                        ((q_step == '0) || (count_reg == CW'(DIGIT_SLOTS - 1)));
        sts.negative  = neg_reg;
        sts.cnt_one   = count_reg == CW'(1);
    end

    assign character = char_reg;
    assign last      = last_reg;

    `ITOA_ASSERT_NOW(a_step_room, cmd.step, count_reg < CW'(DIGIT_SLOTS),
                     "digit written beyond the digit store")
    `ITOA_ASSERT_NOW(a_emit_has_digit, cmd.digit_out || cmd.rd_en, count_reg != '0,
                     "digit emitted with an empty digit store")

endmodule

`default_nettype wire

### rtl/itoa_ctrl.sv
// Controller: sequences conversion, sign and digit emission, and owns the output valid.
`default_nettype none
`include "integer_to_ascii_radix_defines.svh"

module itoa_ctrl
    import itoa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output itoa_cmd_t      cmd,
    input  wire itoa_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_FETCH,
        S_PRESENT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The output register can take a new item when empty or being emptied.
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.step = 1'b1;
                if (sts.conv_last)
                    state_next = S_SIGN;
            end
            S_SIGN:
            begin
                if (!sts.negative)
                    state_next = S_FETCH;
                else if (out_free)
                begin
                    cmd.sign_out = 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_PRESENT;
            end
            S_PRESENT:
            begin
                if (out_free)
                begin
                    cmd.digit_out = 1'b1;
                    state_next    = sts.cnt_one ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid follows loads and completed handshakes.
    always_comb
    begin
        if (cmd.sign_out || cmd.digit_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    `ITOA_ASSERT_NEXT(a_accept_starts_conv, in_valid && !in_stall, state_reg == S_CONV,
                      "accepted item did not start a conversion")
    `ITOA_ASSERT_NOW(a_present_after_fetch, state_reg == S_PRESENT,
                     $past(state_reg) == S_FETCH || $past(state_reg) == S_PRESENT,
                     "digit presented without a store read")

endmodule

`default_nettype wire

### rtl/integer_to_ascii_radix.sv
// Integer to ASCII conversion in octal, decimal or hex, one item at a time.
// Octal and hex give one digit per shift of the quotient; decimal gives one digit
// per pass of all 8-bit chunks through the shared divide-by-ten chunk unit.
// Emission then passes a sign state, whether or not a minus sign is sent, reads
// each digit from the store (store read, then output register), and holds on any
// output stall. Reset clears all control state at once.
`default_nettype none

module integer_to_ascii_radix
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS  = 64,
    parameter int DIGIT_SLOTS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] value,
    input  wire logic [1:0]  size_code,
    input  wire logic        is_signed,
    input  wire logic [1:0]  radix_code,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  character,
    output logic             last
);

    itoa_cmd_t cmd;
    itoa_sts_t sts;

    // Conversion sequencer.
    itoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Division, digit store and output character.
    itoa_dp #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .value      (value),
        .size_code  (size_code),
        .is_signed  (is_signed),
        .radix_code (radix_code),
        .character  (character),
        .last       (last)
    );

endmodule

`default_nettype wire
